### hw/rtl/ddpc_pkg.sv
// Shared constants and types for the two-wheel drive position and heading controller.
`timescale 1ns / 1ps
`default_nettype none
package ddpc_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int PWR_SHIFT = FRAC_BITS - 2;
  localparam int PWR_ONE   = 16384;

  // Shared divider geometry
  localparam int DIV_NW  = 52;
  localparam int DIV_DW  = 32;
  localparam int DIV_CW  = $clog2(DIV_NW);

  // Build constants
  localparam int US_PER_S        = 1000000;
  localparam int DEG_WRAP        = 360;
  localparam int HALF_TURN       = 180;
  localparam int POS_TOL         = 16384;
  localparam int POS_SPEED_TOL   = 32768;
  localparam int ANG_TOL         = 2;
  localparam int ANG_SPEED_TOL   = 131072;
  localparam int TURN_RATE_LIMIT = 5898240;

  // Wheel speed over full speed is speed / 96: a 5-bit shift, then a reciprocal of 3
  // that is exact for shifted speeds below 2^19. Speeds at or above 32768 * 96 clamp.
  localparam int NORM_CLAMP = 3145728;
  localparam int NORM_RECIP = 174763;
  localparam int NORM_SHIFT = 19;

  // Whole degrees over 360 by reciprocal, exact for magnitudes up to 2^17.
  localparam int DEG_RECIP = 93207;
  localparam int DEG_SHIFT = 25;

  // Item kinds carried in tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TARGET = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_FWD_ERR_GAIN = 3'd0;
  localparam logic [2:0] REG_FWD_SPD_GAIN = 3'd1;
  localparam logic [2:0] REG_ANG_ERR_GAIN = 3'd2;
  localparam logic [2:0] REG_ANG_SPD_GAIN = 3'd3;
  localparam logic [2:0] REG_CUR_LIMIT    = 3'd4;
  localparam logic [2:0] REG_BWD_LIMIT    = 3'd5;
  localparam logic [2:0] REG_MIN_POWER    = 3'd6;
  localparam logic [2:0] REG_TURN_LIMIT   = 3'd7;

  // Limits handed to each wheel limiter
  typedef struct packed {
    logic [14:0] cur_limit;
    logic [14:0] bwd_limit;
    logic [14:0] min_power;
  } lim_cfg_t;

endpackage
`default_nettype wire

### hw/rtl/ddpc_divider.sv
// Radix-2 restoring divider shared by all divisions of one control step.
`timescale 1ns / 1ps
`default_nettype none
module ddpc_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ddpc_pkg::DIV_NW-1:0] num,
  input  wire logic [ddpc_pkg::DIV_DW-1:0] den,
  output logic      [ddpc_pkg::DIV_NW-1:0] quo,
  output logic                             done
);

  localparam int NW = ddpc_pkg::DIV_NW;
  localparam int DW = ddpc_pkg::DIV_DW;
  localparam int CW = ddpc_pkg::DIV_CW;

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign trial = {rem_r, quo_r[NW-1]};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[NW-2:0], ge};
        rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule
`default_nettype wire

### hw/rtl/ddpc_limiter.sv
// Per-wheel current limiter, minimum-power floor and output saturation.
`timescale 1ns / 1ps
`default_nettype none
module ddpc_limiter (
  input  wire logic signed [15:0]     speed,
  input  wire logic signed [39:0]     power_in,
  input  wire ddpc_pkg::lim_cfg_t     cfg,
  output logic signed [15:0]          power_out
);

  logic signed [41:0] s, p, cl, bcl, mp, lim, flr;

  always_comb begin
    s   = 42'(speed);
    p   = 42'(power_in);
    cl  = $signed({27'd0, cfg.cur_limit});
    bcl = $signed({27'd0, cfg.bwd_limit});
    mp  = $signed({27'd0, cfg.min_power});

    // Limit the step above wheel speed, and the reverse drive against motion.
    if (p > 0 && s >= 0 && (p - s) > cl) begin
      lim = s + cl;
    end else if (p < 0 && s <= 0 && (s - p) > cl) begin
      lim = s - cl;
    end else if (p < 0 && s >= 0 && p < -bcl) begin
      lim = -bcl;
    end else if (p > 0 && s <= 0 && p > bcl) begin
      lim = bcl;
    end else begin
      lim = p;
    end

    // Raise small nonzero drives to the minimum magnitude.
    if (lim > 0 && lim < mp) begin
      flr = mp;
    end else if (lim < 0 && -lim < mp) begin
      flr = -mp;
    end else begin
      flr = lim;
    end

    if (flr > 42'sd32767) begin
      power_out = 16'sh7FFF;
    end else if (flr < -42'sd32768) begin
      power_out = 16'sh8000;
    end else begin
      power_out = flr[15:0];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/diff_drive_position_heading_controller.sv
// Top level: sequencer, shared multiplier, state and configuration registers.
// A sample item with positive elapsed time raises out_tvalid after four speed divisions
// on the radix-2 divider; with zero or negative elapsed time the divisions are skipped.
// A target item only updates the targets and produces no result.
// One item at a time; a result waits in the output register while the next is accepted.
// Reset (rst_n low, synchronous) clears all speeds, targets, history and the turn
// state, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_position_heading_controller (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // time_us[31:0], right_enc[63:32], left_enc[95:64], heading[127:96],
  // rel_distance[159:128], rel_angle[191:160]
  input  wire logic [191:0] in_tdata,
  // action[0]
  input  wire logic [0:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // right_power[15:0], left_power[31:16], turning[32], zero[39:33]
  output logic [39:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TGT   = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_SMUL  = 4'd3;
  localparam logic [3:0] S_SDIV  = 4'd4;
  localparam logic [3:0] S_SWAIT = 4'd5;
  localparam logic [3:0] S_NMUL  = 4'd6;
  localparam logic [3:0] S_NSET  = 4'd7;
  localparam logic [3:0] S_HMUL  = 4'd8;
  localparam logic [3:0] S_HWRAP = 4'd9;
  localparam logic [3:0] S_M0    = 4'd10;
  localparam logic [3:0] S_M1    = 4'd11;
  localparam logic [3:0] S_M2    = 4'd12;
  localparam logic [3:0] S_M3    = 4'd13;
  localparam logic [3:0] S_M4    = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  localparam int NW = ddpc_pkg::DIV_NW;

  // Configuration registers
  logic signed [15:0] g_ferr_r, g_fspd_r, g_aerr_r, g_aspd_r;
  logic [14:0]        cur_lim_r, bwd_lim_r, min_pwr_r;
  logic [7:0]         turn_lim_r;

  // Captured item
  logic               act_r;
  logic [31:0]        time_r;
  logic signed [31:0] r_enc_r, l_enc_r, head_r, rel_dist_r, rel_ang_r;

  // Controller state
  logic [3:0]         state_r;
  logic [31:0]        last_time_r;
  logic signed [31:0] last_pos_r, last_head_r, last_r_r, last_l_r;
  logic signed [31:0] fwd_spd_r, ang_spd_r;
  logic signed [15:0] r_norm_r, l_norm_r;
  logic signed [31:0] tgt_pos_r, tgt_head_r, turn_start_r;
  logic               turn_flag_r;

  // Working registers
  logic signed [32:0] d_r [4];
  logic [1:0]         k_r;
  logic [31:0]        dt_r;
  logic signed [31:0] pos_r;
  logic [16:0]        emag_r;
  logic               eneg_r;
  logic [31:0]        spmag_r;
  logic               spneg_r;
  logic [15:0]        nq_r;
  logic [7:0]         hq_r;
  logic signed [8:0]  aerr_r;
  logic signed [54:0] pa_r, pb_r;
  logic signed [39:0] angc_r;
  logic signed [32:0] ferr_r;

  // Output register
  logic               out_valid_r;
  logic [39:0]        out_data_r;

  // Combinational helpers
  logic signed [32:0] enc_sum, pos_sum;
  logic signed [31:0] pos_c;
  logic [31:0]        dt_c;
  logic               dt_ok;
  logic signed [32:0] hdiff;
  logic [32:0]        hmag;
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] mul_p;
  logic               div_start, div_done;
  logic [NW-1:0]      div_num, div_quo;
  logic [31:0]        div_den;
  logic [54:0]        pa_mag;
  logic signed [31:0] sp_sat;
  logic [31:0]        sp_mag;
  logic signed [15:0] norm_c;
  logic [16:0]        e_rem;
  logic signed [10:0] e_mod, e_wrap;
  logic signed [31:0] asp, fsp;
  logic               turn_big;
  logic signed [32:0] fwd_diff;
  logic signed [63:0] asum;
  logic signed [55:0] fsum;
  logic signed [41:0] fc_full;
  logic signed [15:0] fc;
  logic signed [39:0] rp_in, lp_in;
  logic signed [15:0] rp, lp;
  ddpc_pkg::lim_cfg_t lim_cfg;
  logic               fin_load;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] dband32(input logic signed [31:0] v,
                                                 input logic signed [32:0] tol);
    logic signed [32:0] w;
    w = 33'(v);
    return (w < tol && w > -tol) ? 32'sd0 : v;
  endfunction

  // Item fields
  assign in_tready = (state_r == S_IDLE);

  // Position average truncated toward zero.
  assign enc_sum = 33'(r_enc_r) + 33'(l_enc_r);
  assign pos_sum = enc_sum + ((enc_sum[32] && enc_sum[0]) ? 33'sd1 : 33'sd0);
  assign pos_c   = pos_sum[32:1];

  assign dt_c  = time_r - last_time_r;
  assign dt_ok = (dt_c != 32'd0) && !dt_c[31];

  // Heading error magnitude in whole degrees, truncated toward zero.
  assign hdiff = 33'(tgt_head_r) - 33'(head_r);
  assign hmag  = hdiff[32] ? 33'(-hdiff) : 33'(hdiff);

  assign asp = dband32(ang_spd_r, 33'(ddpc_pkg::ANG_SPEED_TOL));
  assign fsp = dband32(fwd_spd_r, 33'(ddpc_pkg::POS_SPEED_TOL));

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_r)
      S_SMUL: begin
        mul_a = 34'(d_r[k_r]);
        mul_b = 21'(ddpc_pkg::US_PER_S);
      end
      S_NMUL: begin
        mul_a = 34'(spmag_r[31:5]);
        mul_b = 21'(ddpc_pkg::NORM_RECIP);
      end
      S_HMUL: begin
        mul_a = 34'(emag_r);
        mul_b = 21'(ddpc_pkg::DEG_RECIP);
      end
      S_M0: begin
        mul_a = 34'(aerr_r);
        mul_b = 21'(g_aerr_r);
      end
      S_M1: begin
        mul_a = 34'(asp);
        mul_b = 21'(g_aspd_r);
      end
      S_M3: begin
        mul_a = 34'(ferr_r);
        mul_b = 21'(g_ferr_r);
      end
      S_M4: begin
        mul_a = 34'(fsp);
        mul_b = 21'(g_fspd_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = 55'(mul_a) * 55'(mul_b);

  // Divider operands: scaled travel over elapsed time.
  assign pa_mag = pa_r[54] ? 55'(-pa_r) : 55'(pa_r);
  always_comb begin
    if (state_r == S_SDIV) begin
      div_num = pa_mag[NW-1:0];
      div_den = dt_r;
    end else begin
      div_num = '0;
      div_den = 32'd1;
    end
  end
  assign div_start = (state_r == S_SDIV);

  ddpc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Speed quotient saturated to 32 bits, with its magnitude for normalization.
  always_comb begin
    if (!spneg_r) begin
      sp_mag = (div_quo > NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_quo[31:0];
      sp_sat = $signed(sp_mag);
    end else begin
      sp_mag = (div_quo > NW'(32'h80000000)) ? 32'h80000000 : div_quo[31:0];
      sp_sat = $signed(-sp_mag);
    end
  end

  // Normalized wheel speed clamped to 16 bits.
  always_comb begin
    if (spmag_r >= 32'(ddpc_pkg::NORM_CLAMP)) begin
      norm_c = spneg_r ? 16'sh8000 : 16'sh7FFF;
    end else begin
      norm_c = spneg_r ? -$signed(nq_r) : $signed(nq_r);
    end
  end

  // Remainder with the dividend's sign, wrapped into the half-turn range.
  always_comb begin
    e_rem = emag_r - 17'(hq_r) * 17'(ddpc_pkg::DEG_WRAP);
    e_mod = eneg_r ? -$signed({2'b00, e_rem[8:0]}) : $signed({2'b00, e_rem[8:0]});
    if (e_mod < -11'(ddpc_pkg::HALF_TURN)) begin
      e_wrap = e_mod + 11'(ddpc_pkg::DEG_WRAP);
    end else if (e_mod > 11'(ddpc_pkg::HALF_TURN)) begin
      e_wrap = e_mod - 11'(ddpc_pkg::DEG_WRAP);
    end else begin
      e_wrap = e_mod;
    end
  end

  // Turning condition on heading error or rate.
  assign turn_big = ($signed({{2{aerr_r[8]}}, aerr_r}) > $signed({3'b000, turn_lim_r})) ||
                    (-$signed({{2{aerr_r[8]}}, aerr_r}) > $signed({3'b000, turn_lim_r})) ||
                    (asp > 32'(ddpc_pkg::TURN_RATE_LIMIT)) ||
                    (asp < -32'(ddpc_pkg::TURN_RATE_LIMIT));

  assign fwd_diff = (turn_flag_r ? 33'(turn_start_r) : 33'(tgt_pos_r)) - 33'(pos_r);

  // PD sums shifted to Q1.14, rounding toward minus infinity.
  assign asum = $signed({pa_r[47:0], 16'd0}) + 64'(pb_r);
  assign fsum = 56'(pa_r) + 56'(pb_r);
  assign fc_full = 42'(fsum >>> ddpc_pkg::PWR_SHIFT);
  always_comb begin
    if (fc_full > 42'(ddpc_pkg::PWR_ONE)) begin
      fc = 16'(ddpc_pkg::PWR_ONE);
    end else if (fc_full < -42'(ddpc_pkg::PWR_ONE)) begin
      fc = -16'(ddpc_pkg::PWR_ONE);
    end else begin
      fc = fc_full[15:0];
    end
  end
  assign rp_in = 40'(fc) - angc_r;
  assign lp_in = 40'(fc) + angc_r;

  assign lim_cfg.cur_limit = cur_lim_r;
  assign lim_cfg.bwd_limit = bwd_lim_r;
  assign lim_cfg.min_power = min_pwr_r;

  ddpc_limiter u_lim_right (
    .speed     (r_norm_r),
    .power_in  (rp_in),
    .cfg       (lim_cfg),
    .power_out (rp)
  );

  ddpc_limiter u_lim_left (
    .speed     (l_norm_r),
    .power_in  (lp_in),
    .cfg       (lim_cfg),
    .power_out (lp)
  );

  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_ferr_r   <= '0;
      g_fspd_r   <= '0;
      g_aerr_r   <= '0;
      g_aspd_r   <= '0;
      cur_lim_r  <= 15'd8192;
      bwd_lim_r  <= 15'd8192;
      min_pwr_r  <= '0;
      turn_lim_r <= 8'd30;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ddpc_pkg::REG_FWD_ERR_GAIN: g_ferr_r   <= cfg_wdata;
        ddpc_pkg::REG_FWD_SPD_GAIN: g_fspd_r   <= cfg_wdata;
        ddpc_pkg::REG_ANG_ERR_GAIN: g_aerr_r   <= cfg_wdata;
        ddpc_pkg::REG_ANG_SPD_GAIN: g_aspd_r   <= cfg_wdata;
        ddpc_pkg::REG_CUR_LIMIT:    cur_lim_r  <= cfg_wdata[14:0];
        ddpc_pkg::REG_BWD_LIMIT:    bwd_lim_r  <= cfg_wdata[14:0];
        ddpc_pkg::REG_MIN_POWER:    min_pwr_r  <= cfg_wdata[14:0];
        ddpc_pkg::REG_TURN_LIMIT:   turn_lim_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Item capture on input transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r      <= in_tuser[0];
      time_r     <= in_tdata[31:0];
      r_enc_r    <= in_tdata[63:32];
      l_enc_r    <= in_tdata[95:64];
      head_r     <= in_tdata[127:96];
      rel_dist_r <= in_tdata[159:128];
      rel_ang_r  <= in_tdata[191:160];
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_PREP: begin
        pos_r  <= pos_c;
        dt_r   <= dt_c;
        d_r[0] <= 33'(pos_c) - 33'(last_pos_r);
        d_r[1] <= 33'(head_r) - 33'(last_head_r);
        d_r[2] <= 33'(r_enc_r) - 33'(last_r_r);
        d_r[3] <= 33'(l_enc_r) - 33'(last_l_r);
        emag_r <= hmag[32:16];
        eneg_r <= hdiff[32];
      end
      S_SMUL: begin
        pa_r    <= mul_p;
        spneg_r <= mul_p[54];
      end
      S_SWAIT: begin
        if (div_done) begin
          spmag_r <= sp_mag;
        end
      end
      S_NMUL:  nq_r <= mul_p[ddpc_pkg::NORM_SHIFT +: 16];
      S_HMUL:  hq_r <= mul_p[ddpc_pkg::DEG_SHIFT +: 8];
      S_HWRAP: begin
        aerr_r <= (e_wrap < 11'(ddpc_pkg::ANG_TOL) && e_wrap > -11'(ddpc_pkg::ANG_TOL)) ?
                  9'sd0 : e_wrap[8:0];
      end
      S_M0: pa_r <= mul_p;
      S_M1: pb_r <= mul_p;
      S_M2: begin
        angc_r <= 40'(asum >>> ddpc_pkg::PWR_SHIFT);
        ferr_r <= (fwd_diff < 33'(ddpc_pkg::POS_TOL) && fwd_diff > -33'(ddpc_pkg::POS_TOL)) ?
                  33'sd0 : fwd_diff;
      end
      S_M3: pa_r <= mul_p;
      S_M4: pb_r <= mul_p;
      default: ;
    endcase
  end

  // Sequencer and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      last_time_r  <= '0;
      last_pos_r   <= '0;
      last_head_r  <= '0;
      last_r_r     <= '0;
      last_l_r     <= '0;
      fwd_spd_r    <= '0;
      ang_spd_r    <= '0;
      r_norm_r     <= '0;
      l_norm_r     <= '0;
      tgt_pos_r    <= '0;
      tgt_head_r   <= '0;
      turn_flag_r  <= 1'b0;
      turn_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !fin_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= (in_tuser[0] == ddpc_pkg::ACT_TARGET) ? S_TGT : S_PREP;
          end
        end
        S_TGT: begin
          tgt_head_r <= sat33(33'(head_r) + 33'(rel_ang_r));
          tgt_pos_r  <= sat33(33'(pos_c) + 33'(rel_dist_r));
          state_r    <= S_IDLE;
        end
        S_PREP: begin
          last_time_r <= time_r;
          last_pos_r  <= pos_c;
          last_head_r <= head_r;
          last_r_r    <= r_enc_r;
          last_l_r    <= l_enc_r;
          k_r         <= 2'd0;
          state_r     <= dt_ok ? S_SMUL : S_HMUL;
        end
        S_SMUL:  state_r <= S_SDIV;
        S_SDIV:  state_r <= S_SWAIT;
        S_SWAIT: begin
          if (div_done) begin
            if (k_r == 2'd0) begin
              fwd_spd_r <= sp_sat;
              k_r       <= 2'd1;
              state_r   <= S_SMUL;
            end else if (k_r == 2'd1) begin
              ang_spd_r <= sp_sat;
              k_r       <= 2'd2;
              state_r   <= S_SMUL;
            end else begin
              state_r   <= S_NMUL;
            end
          end
        end
        S_NMUL:  state_r <= S_NSET;
        S_NSET: begin
          if (k_r == 2'd2) begin
            r_norm_r <= norm_c;
            k_r      <= 2'd3;
            state_r  <= S_SMUL;
          end else begin
            l_norm_r <= norm_c;
            state_r  <= S_HMUL;
          end
        end
        S_HMUL:  state_r <= S_HWRAP;
        S_HWRAP: state_r <= S_M0;
        S_M0:    state_r <= S_M1;
        S_M1: begin
          if (turn_big) begin
            if (!turn_flag_r) begin
              turn_start_r <= pos_r;
              turn_flag_r  <= 1'b1;
            end
          end else begin
            turn_flag_r <= 1'b0;
          end
          state_r <= S_M2;
        end
        S_M2:    state_r <= S_M3;
        S_M3:    state_r <= S_M4;
        S_M4:    state_r <= S_FIN;
        S_FIN: begin
          if (fin_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_data_r <= {7'd0, turn_flag_r, lp, rp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A transferred target item enters the target update, which produces no result and returns to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == ddpc_pkg::ACT_TARGET) |=> (state_r == S_TGT))
    else $error("target item did not enter the target update");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_SWAIT))
    else $error("divider finished outside a wait state");

  // Entering the turning state records the current position.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(turn_flag_r) |-> (turn_start_r == pos_r))
    else $error("turn start position not captured");

  // A finished step always leaves a result waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result lost at end of step");

endmodule
`default_nettype wire
